>>> design/tun_pkg.sv
// Package: transaction payload types and fixed constants of the triangle unit normal block.
package tun_pkg;

    // Number of normal components handled side by side.
    localparam int NUM_LANES = 3;
    // Width of every coordinate and output field as seen on the ports.
    localparam int FIELD_W = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] p0_x;
        logic signed [FIELD_W-1:0] p0_y;
        logic signed [FIELD_W-1:0] p0_z;
        logic signed [FIELD_W-1:0] p1_x;
        logic signed [FIELD_W-1:0] p1_y;
        logic signed [FIELD_W-1:0] p1_z;
        logic signed [FIELD_W-1:0] p2_x;
        logic signed [FIELD_W-1:0] p2_y;
        logic signed [FIELD_W-1:0] p2_z;
    } in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] norm_x;
        logic signed [FIELD_W-1:0] norm_y;
        logic signed [FIELD_W-1:0] norm_z;
        logic                      degenerate;
    } out_t;

endpackage

>>> design/tun_front.sv
// Front pipeline: edge vectors, cross product, squared components and squared length.
module tun_front #(
    parameter int CW = 32,
    parameter int F  = 30,
    parameter int WW = 200
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tun_pkg::in_t                  in_data,
    output logic                          down_valid,
    input  logic                          down_ready,
    output logic [WW-1:0]                 s_out,
    output logic [WW-1:0]                 t_out [tun_pkg::NUM_LANES],
    output logic [tun_pkg::NUM_LANES-1:0] neg_out
);
    import tun_pkg::*;

    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int AW  = NW - 1;
    localparam int LO  = AW / 2;
    localparam int HI  = AW - LO;
    localparam int SQW = 2 * AW;
    localparam int NST = 5;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    logic signed [DW-1:0] d_reg [6];
    logic signed [PW-1:0] m_reg [6];
    logic [AW-1:0]        mag_reg [NUM_LANES];
    logic [2*HI-1:0]      hh_reg [NUM_LANES];
    logic [HI+LO-1:0]     hl_reg [NUM_LANES];
    logic [2*LO-1:0]      ll_reg [NUM_LANES];
    logic [SQW-1:0]       sq_reg [NUM_LANES];
    logic [NUM_LANES-1:0] n3_reg, n4_reg, n5_reg;

    logic signed [DW-1:0] c [9];
    logic signed [NW-1:0] n [NUM_LANES];

    // A stage takes new data when it is empty or its contents move on.
    always_comb
    begin
        rdy[NST] = down_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready   = rdy[0];
    assign down_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Coordinates taken from the low bits of each field.
    assign c[0] = DW'($signed(in_data.p0_x[CW-1:0]));
    assign c[1] = DW'($signed(in_data.p0_y[CW-1:0]));
    assign c[2] = DW'($signed(in_data.p0_z[CW-1:0]));
    assign c[3] = DW'($signed(in_data.p1_x[CW-1:0]));
    assign c[4] = DW'($signed(in_data.p1_y[CW-1:0]));
    assign c[5] = DW'($signed(in_data.p1_z[CW-1:0]));
    assign c[6] = DW'($signed(in_data.p2_x[CW-1:0]));
    assign c[7] = DW'($signed(in_data.p2_y[CW-1:0]));
    assign c[8] = DW'($signed(in_data.p2_z[CW-1:0]));

    // Cross product components from the registered products.
    assign n[0] = NW'(m_reg[0]) - NW'(m_reg[1]);
    assign n[1] = NW'(m_reg[2]) - NW'(m_reg[3]);
    assign n[2] = NW'(m_reg[4]) - NW'(m_reg[5]);

    // Payload stages; d index: 0..2 edge b, 3..5 edge c.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]   <= c[3+i] - c[i];
                d_reg[3+i] <= c[6+i] - c[i];
            end
        end
        if (rdy[1])
        begin
            m_reg[0] <= PW'(d_reg[1]) * PW'(d_reg[5]);
            m_reg[1] <= PW'(d_reg[4]) * PW'(d_reg[2]);
            m_reg[2] <= PW'(d_reg[2]) * PW'(d_reg[3]);
            m_reg[3] <= PW'(d_reg[5]) * PW'(d_reg[0]);
            m_reg[4] <= PW'(d_reg[0]) * PW'(d_reg[4]);
            m_reg[5] <= PW'(d_reg[3]) * PW'(d_reg[1]);
        end
        if (rdy[2])
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                n3_reg[i]  <= n[i][NW-1];
                mag_reg[i] <= n[i][NW-1] ? AW'(-n[i]) : AW'(n[i]);
            end
        end
        if (rdy[3])
        begin
            n4_reg <= n3_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                hh_reg[i] <= (2*HI)'(mag_reg[i][AW-1:LO]) * (2*HI)'(mag_reg[i][AW-1:LO]);
                hl_reg[i] <= (HI+LO)'(mag_reg[i][AW-1:LO]) * (HI+LO)'(mag_reg[i][LO-1:0]);
                ll_reg[i] <= (2*LO)'(mag_reg[i][LO-1:0]) * (2*LO)'(mag_reg[i][LO-1:0]);
            end
        end
        if (rdy[4])
        begin
            n5_reg <= n4_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2*LO)) + (SQW'(hl_reg[i]) << (LO+1))
                             + SQW'(ll_reg[i]);
            end
        end
    end

    // The fifth valid bit covers the sum stage; sq feeds it combinationally.
    assign s_out   = WW'(sq_reg[0]) + WW'(sq_reg[1]) + WW'(sq_reg[2]);
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            t_out[i] = WW'(sq_reg[i]) << (2*F);
        end
    end
    assign neg_out = n5_reg;

endmodule

>>> design/tun_cell.sv
// One cell of the root chain: settles one bit of the normal for all three components.
module tun_cell #(
    parameter int WW  = 200,
    parameter int QW  = 31,
    parameter int BIT = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [WW-1:0]                 s_in,
    input  logic [WW-1:0]                 r_in [tun_pkg::NUM_LANES],
    input  logic [WW-1:0]                 y_in [tun_pkg::NUM_LANES],
    input  logic [QW-1:0]                 q_in [tun_pkg::NUM_LANES],
    input  logic [tun_pkg::NUM_LANES-1:0] neg_in,
    output logic                          down_valid,
    input  logic                          down_ready,
    output logic [WW-1:0]                 s_out,
    output logic [WW-1:0]                 r_out [tun_pkg::NUM_LANES],
    output logic [WW-1:0]                 y_out [tun_pkg::NUM_LANES],
    output logic [QW-1:0]                 q_out [tun_pkg::NUM_LANES],
    output logic [tun_pkg::NUM_LANES-1:0] neg_out
);
    import tun_pkg::*;

    logic                 valid_reg;
    logic [WW-1:0]        s_reg;
    logic [WW-1:0]        r_reg [NUM_LANES];
    logic [WW-1:0]        y_reg [NUM_LANES];
    logic [QW-1:0]        q_reg [NUM_LANES];
    logic [NUM_LANES-1:0] neg_reg;
    logic [WW-1:0]        delta [NUM_LANES];
    logic [NUM_LANES-1:0] take;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;

    // Cost of setting this bit: ((2*q*s + 2^b*s) * 2^b), compared with the remainder.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            delta[i] = ((y_in[i] << 1) + (s_in << BIT)) << BIT;
            take[i]  = delta[i] <= r_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            s_reg   <= s_in;
            neg_reg <= neg_in;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                r_reg[i] <= take[i] ? r_in[i] - delta[i] : r_in[i];
                y_reg[i] <= take[i] ? y_in[i] + (s_in << BIT) : y_in[i];
                q_reg[i] <= q_in[i] | (take[i] ? (QW'(1) << BIT) : QW'(0));
            end
        end
    end

    assign s_out   = s_reg;
    assign r_out   = r_reg;
    assign y_out   = y_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;

endmodule

>>> design/triangle_unit_normal_unit.sv
// Top level: unit face normal of a triangle, front pipeline, root cell chain and output register.
//
// Each transaction carries the three corners of one triangle and gives one result: the
// unit normal truncated toward zero with NORM_FRAC_BITS fraction bits, or zeros with the
// degenerate flag when the cross product vanishes. One triangle is taken every cycle
// unless the result side stalls; the path runs through five front stages (edges, products, cross
// product, partial squares, squares), one cell per result bit, and the output register.
// Every stage holds its own item, so a stall on the result side only backs up as far as
// the pipeline is full.
module triangle_unit_normal_unit #(
    parameter int COORD_WIDTH    = 32,
    parameter int NORM_FRAC_BITS = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tun_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output tun_pkg::out_t out_data
);
    import tun_pkg::*;

    localparam int F    = NORM_FRAC_BITS;
    localparam int AW   = 2 * (COORD_WIDTH + 1);
    localparam int WW   = 2 * AW + 2 + 2 * F + 2;
    localparam int QW   = F + 1;
    localparam int NC   = F + 1;

    logic                 fr_ready;
    logic                 cv [NC+1];
    logic                 cr [NC+1];
    logic [WW-1:0]        cs [NC+1];
    logic [WW-1:0]        crr [NC+1][NUM_LANES];
    logic [WW-1:0]        cy [NC+1][NUM_LANES];
    logic [QW-1:0]        cq [NC+1][NUM_LANES];
    logic [NUM_LANES-1:0] cn [NC+1];

    logic                 out_valid_reg;
    out_t                 out_reg;
    out_t                 out_next;
    logic                 deg;
    logic signed [FIELD_W-1:0] comp [NUM_LANES];

    assign in_stall = !fr_ready;

    // Edges, cross product and squared length.
    tun_front #(.CW(COORD_WIDTH), .F(F), .WW(WW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (fr_ready),
        .in_data   (in_data),
        .down_valid(cv[0]),
        .down_ready(cr[0]),
        .s_out     (cs[0]),
        .t_out     (crr[0]),
        .neg_out   (cn[0])
    );

    // The chain starts with an empty quotient and no accumulated cost.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_seed
        assign cy[0][i] = '0;
        assign cq[0][i] = '0;
    end

    // Root chain, highest bit first.
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        tun_cell #(.WW(WW), .QW(QW), .BIT(F - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (cv[g]),
            .up_ready  (cr[g]),
            .s_in      (cs[g]),
            .r_in      (crr[g]),
            .y_in      (cy[g]),
            .q_in      (cq[g]),
            .neg_in    (cn[g]),
            .down_valid(cv[g+1]),
            .down_ready(cr[g+1]),
            .s_out     (cs[g+1]),
            .r_out     (crr[g+1]),
            .y_out     (cy[g+1]),
            .q_out     (cq[g+1]),
            .neg_out   (cn[g+1])
        );
    end

    // Sign, degenerate case and output register.
    assign cr[NC] = !out_valid_reg || !out_stall;
    assign deg    = cs[NC] == '0;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            comp[i] = deg ? '0
                    : (cn[NC][i] ? -FIELD_W'(cq[NC][i]) : FIELD_W'(cq[NC][i]));
        end
        out_next.norm_x     = comp[0];
        out_next.norm_y     = comp[1];
        out_next.norm_z     = comp[2];
        out_next.degenerate = deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cr[NC])
        begin
            out_valid_reg <= cv[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cr[NC] && cv[NC])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A degenerate result carries a zero normal.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0)
        else $error("degenerate result with non-zero normal");

    // The x component does not exceed one in magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.norm_x <= $signed(FIELD_W'(1) << F)
            && out_data.norm_x >= -$signed(FIELD_W'(1) << F))
        else $error("normal component out of range");

    // An item leaving the chain appears at the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cv[NC] && cr[NC] |=> out_valid_reg)
        else $error("transaction lost between chain and output");

endmodule
